@@ design/bse_pkg.sv @@
// Shared constants, types and helper functions for the bitmap set engine.
`timescale 1ns / 1ps

package bse_pkg;

    // Geometry of the stored set
    localparam int WORD_COUNT = 64;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CAP_BITS   = WORD_COUNT * WORD_BITS;

    // Field widths
    localparam int SIZE_W = 12;
    localparam int UW_W   = SIZE_W - BIT_W + 1;
    localparam int OP_W   = 4;
    localparam int WI_W   = 6;
    localparam int BIDX_W = 11;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_BITS  = OP_W + WI_W + WORD_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = WORD_BITS + BIDX_W + 6;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Result field positions inside the output tdata
    localparam int O_BIDX_LSB = WORD_BITS;
    localparam int O_FOUND    = O_BIDX_LSB + BIDX_W;
    localparam int O_EMPTY    = O_FOUND + 1;
    localparam int O_EQUAL    = O_EMPTY + 1;
    localparam int O_DISJOINT = O_EQUAL + 1;
    localparam int O_SUBSET   = O_DISJOINT + 1;
    localparam int O_BAD      = O_SUBSET + 1;

    localparam logic [SIZE_W-1:0] RESET_SIZE =
        (CAP_BITS < 2048) ? SIZE_W'(CAP_BITS) : SIZE_W'(2048);

    // Compare accumulator bits
    localparam int F_EQUAL    = 0;
    localparam int F_DISJOINT = 1;
    localparam int F_SUBSET   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 4'd0,
        OP_SETALL    = 4'd1,
        OP_WRITE     = 4'd2,
        OP_READ      = 4'd3,
        OP_UNION     = 4'd4,
        OP_INTERSECT = 4'd5,
        OP_SUBTRACT  = 4'd6,
        OP_COMPARE   = 4'd7,
        OP_ITERSTART = 4'd8,
        OP_ITERNEXT  = 4'd9
    } t_op;

    // Force a requested size into 1 .. capacity
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (int'(v) > CAP_BITS) begin
            r = SIZE_W'(CAP_BITS);
        end
        return r;
    endfunction

    // Number of words that hold live bits
    function automatic logic [UW_W-1:0] used_words(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m1;
        m1 = size - 1'b1;
        return UW_W'(m1[SIZE_W-1:BIT_W]) + 1'b1;
    endfunction

    // Bits of word idx that lie below the set size
    function automatic logic [WORD_BITS-1:0] valid_mask(input logic [SIZE_W-1:0] size,
                                                        input logic [UW_W-1:0] idx);
        logic [UW_W-1:0]      uw;
        logic [BIT_W-1:0]     rem;
        logic [WORD_BITS-1:0] m;
        uw  = used_words(size);
        rem = size[BIT_W-1:0];
        if (idx >= uw) begin
            m = '0;
        end else if ((idx + 1'b1) < uw || rem == '0) begin
            m = '1;
        end else begin
            m = (WORD_BITS'(1) << rem) - 1'b1;
        end
        return m;
    endfunction

    // Lowest set bit of the word map
    function automatic logic [ADDR_W-1:0] first_word(input logic [WORD_COUNT-1:0] v);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = ADDR_W'(i);
            end
        end
        return r;
    endfunction

    // Lowest set bit of a data word
    function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ design/bse_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ design/bitmap_set_engine.sv @@
// Top level of the bitmap set engine: word store, nonzero map, iterator and control.
`timescale 1ns / 1ps

// The set lives in a 64 x 32 word RAM with a registered read, next to a
// 64-bit flip-flop map that marks which words are nonzero; a word whose map bit is
// clear reads as zero, so reset and clear act at once on the map alone. Write, read,
// union, intersect, subtract and compare read a live addressed word from the RAM, and
// write, union, intersect and subtract modify it and write it back; clear, iterstart
// and unused opcodes read no word. One request is worked at a time, so no access
// overlaps another. Setall writes every word. For iternext the map picks the next
// nonzero word, and at most two RAM reads settle the bit. A write of set_size starts
// a pass that reads and re-masks every word, during which no request is taken.
// The result sits in an output register, so the next request is taken while a result
// still waits.
module bitmap_set_engine
    import bse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write: set_size
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    // request: op, word_index, word_value (from bit 0 up)
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    // result: read_word, bit_index, found, is_empty, equal_so_far,
    //         disjoint_so_far, subset_so_far, bad_index (from bit 0 up)
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_ITER,
        S_FINISH,
        S_CFG_RD,
        S_CFG_WR
    } t_state;

    t_state                r_state,  n_state;
    logic [SIZE_W-1:0]     r_size,   n_size;
    logic [WORD_COUNT-1:0] r_map,    n_map;
    logic [SIZE_W-1:0]     r_cursor, n_cursor;
    logic [2:0]            r_flags,  n_flags;
    t_op                   r_op,     n_op;
    logic [WI_W-1:0]       r_wi,     n_wi;
    logic [WORD_BITS-1:0]  r_wv,     n_wv;
    logic                  r_bad,    n_bad;
    logic                  r_found,  n_found;
    logic [BIDX_W-1:0]     r_bidx,   n_bidx;
    logic [ADDR_W-1:0]     r_idx,    n_idx;
    logic                  r_ovalid, n_ovalid;
    logic [OUT_W-1:0]      r_odata,  n_odata;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    t_op                   in_op;
    logic [WI_W-1:0]       in_wi;
    logic [WORD_BITS-1:0]  in_wv;
    logic                  in_indexed;
    logic                  in_take;
    logic                  out_free;
    logic [UW_W-1:0]       uw;
    logic [UW_W-1:0]       cur_word;
    logic [UW_W-1:0]       scan_base;
    logic [WORD_COUNT-1:0] hits;
    logic [WORD_BITS-1:0]  rd_eff;
    logic [WORD_BITS-1:0]  scan_word;
    logic [WORD_BITS-1:0]  new_word;
    logic [WORD_BITS-1:0]  res_word;
    logic                  do_store;
    logic [2:0]            cmp_base;

    bse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Unpack the request
    assign in_op = t_op'(i_s_tdata[OP_W-1:0]);
    assign in_wi = i_s_tdata[OP_W +: WI_W];
    assign in_wv = i_s_tdata[OP_W + WI_W +: WORD_BITS];

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_take     = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    assign in_indexed = (in_op == OP_WRITE) || (in_op == OP_READ) ||
                        (in_op == OP_UNION) || (in_op == OP_INTERSECT) ||
                        (in_op == OP_SUBTRACT) || (in_op == OP_COMPARE);

    assign uw       = used_words(r_size);
    assign cur_word = UW_W'(r_cursor[SIZE_W-1:BIT_W]);

    // A word whose map bit is clear reads as zero
    assign rd_eff = r_map[r_idx] ? ram_rdata : '0;

    // Next nonzero word at or above the scan base
    assign scan_base = (r_state == S_ITER) ? (UW_W'(r_idx) + 1'b1) : cur_word;
    assign hits      = r_map & ({WORD_COUNT{1'b1}} << scan_base);

    // Drop bits below the cursor in the cursor's own word
    assign scan_word = (UW_W'(r_idx) == cur_word)
                     ? (rd_eff & ({WORD_BITS{1'b1}} << r_cursor[BIT_W-1:0]))
                     : rd_eff;

    // Merge or compare one stored word against the request
    always_comb begin
        new_word = rd_eff;
        res_word = rd_eff;
        do_store = 1'b0;
        cmp_base = (r_wi == '0) ? 3'b111 : r_flags;
        n_flags  = r_flags;
        case (r_op)
            OP_WRITE: begin
                new_word = r_wv;
                do_store = 1'b1;
            end
            OP_UNION: begin
                new_word = rd_eff | r_wv;
                res_word = new_word;
                do_store = 1'b1;
            end
            OP_INTERSECT: begin
                new_word = rd_eff & r_wv;
                res_word = new_word;
                do_store = 1'b1;
            end
            OP_SUBTRACT: begin
                new_word = rd_eff & ~r_wv;
                res_word = new_word;
                do_store = 1'b1;
            end
            OP_COMPARE: begin
                n_flags = cmp_base;
                if (rd_eff != r_wv) begin
                    n_flags[F_EQUAL] = 1'b0;
                end
                if ((rd_eff & r_wv) != '0) begin
                    n_flags[F_DISJOINT] = 1'b0;
                end
                if ((rd_eff & ~r_wv) != '0) begin
                    n_flags[F_SUBSET] = 1'b0;
                end
            end
            OP_READ: begin
                res_word = rd_eff;
            end
            default: begin
                res_word = '0;
            end
        endcase
        if (r_bad || r_state != S_FINISH) begin
            res_word = '0;
            do_store = 1'b0;
            n_flags  = r_flags;
        end
    end

    // Sequencer: next state, RAM control, map, cursor and result
    always_comb begin
        n_state  = r_state;
        n_size   = r_size;
        n_map    = r_map;
        n_cursor = r_cursor;
        n_op     = r_op;
        n_wi     = r_wi;
        n_wv     = r_wv;
        n_bad    = r_bad;
        n_found  = r_found;
        n_bidx   = r_bidx;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_op    = in_op;
                    n_wi    = in_wi;
                    n_wv    = in_wv & valid_mask(r_size, UW_W'(in_wi));
                    n_bad   = in_indexed && (UW_W'(in_wi) >= uw);
                    n_found = 1'b0;
                    n_bidx  = '0;
                    n_idx   = ADDR_W'(in_wi);
                    n_state = S_FINISH;
                    case (in_op)
                        OP_CLEAR: begin
                            n_map = '0;
                        end
                        OP_SETALL: begin
                            for (int i = 0; i < WORD_COUNT; i++) begin
                                n_map[i] = (UW_W'(i) < uw);
                            end
                            n_idx   = '0;
                            n_state = S_FILL;
                        end
                        OP_ITERSTART: begin
                            n_cursor = '0;
                        end
                        OP_ITERNEXT: begin
                            if (r_cursor >= r_size || hits == '0) begin
                                n_cursor = r_size;
                            end else begin
                                n_idx     = first_word(hits);
                                ram_re    = 1'b1;
                                ram_raddr = first_word(hits);
                                n_state   = S_ITER;
                            end
                        end
                        default: begin
                            // Fetch the addressed word for indexed requests with a live index
                            if (in_indexed && !(UW_W'(in_wi) >= uw)) begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(in_wi);
                            end
                        end
                    endcase
                end else if (i_cfg_valid) begin
                    n_size  = clamp_size(i_cfg_data);
                    n_idx   = '0;
                    n_state = S_CFG_RD;
                end
            end

            S_FILL: begin
                // Write every word with the bits that lie inside the set
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = valid_mask(r_size, UW_W'(r_idx));
                if (r_idx == ADDR_W'(WORD_COUNT - 1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_ITER: begin
                if (scan_word != '0) begin
                    n_found  = 1'b1;
                    n_bidx   = BIDX_W'({r_idx, first_bit(scan_word)});
                    n_cursor = SIZE_W'({r_idx, first_bit(scan_word)}) + 1'b1;
                    n_state  = S_FINISH;
                end else if (hits == '0) begin
                    n_cursor = r_size;
                    n_state  = S_FINISH;
                end else begin
                    n_idx     = first_word(hits);
                    ram_re    = 1'b1;
                    ram_raddr = first_word(hits);
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    if (do_store) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_idx;
                        ram_wdata    = new_word;
                        n_map[r_idx] = (new_word != '0);
                    end
                    n_odata = '0;
                    n_odata[WORD_BITS-1:0]          = res_word;
                    n_odata[O_BIDX_LSB +: BIDX_W]   = r_bidx;
                    n_odata[O_FOUND]                = r_found;
                    n_odata[O_EMPTY]                = (n_map == '0);
                    n_odata[O_EQUAL]                = n_flags[F_EQUAL];
                    n_odata[O_DISJOINT]             = n_flags[F_DISJOINT];
                    n_odata[O_SUBSET]               = n_flags[F_SUBSET];
                    n_odata[O_BAD]                  = r_bad;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_CFG_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = S_CFG_WR;
            end

            S_CFG_WR: begin
                // Re-mask the word to the new size and refresh its map bit
                ram_we       = 1'b1;
                ram_waddr    = r_idx;
                ram_wdata    = rd_eff & valid_mask(r_size, UW_W'(r_idx));
                n_map[r_idx] = ((rd_eff & valid_mask(r_size, UW_W'(r_idx))) != '0);
                if (r_idx == ADDR_W'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CFG_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, set contents bookkeeping and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= RESET_SIZE;
            r_map    <= '0;
            r_cursor <= '0;
            r_flags  <= 3'b111;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_map    <= n_map;
            r_cursor <= n_cursor;
            r_flags  <= n_flags;
            r_ovalid <= n_ovalid;
            r_op     <= n_op;
            r_wi     <= n_wi;
            r_wv     <= n_wv;
            r_bad    <= n_bad;
            r_found  <= n_found;
            r_bidx   <= n_bidx;
            r_idx    <= n_idx;
            r_odata  <= n_odata;
        end
    end

endmodule

@@ design/bse_checker.sv @@
// Port-level checks for the bitmap set engine, bound to the top level.
`timescale 1ns / 1ps

module bse_checker
    import bse_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // A stalled result holds its payload
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result payload changed while stalled");

    // A rejected index returns no word and no found bit
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[O_BAD] |->
            (o_m_tdata[WORD_BITS-1:0] == '0) && !o_m_tdata[O_FOUND])
        else $error("bad index result carries data");

    // A found bit means the set is not empty
    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[O_FOUND] |-> !o_m_tdata[O_EMPTY])
        else $error("bit found in an empty set");

    // Without a found bit the bit index is zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[O_FOUND] |->
            (o_m_tdata[O_BIDX_LSB +: BIDX_W] == '0))
        else $error("bit index set without a found bit");

    // A size write starts the re-mask pass, which holds off requests
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_s_tready && !o_cfg_ready)
        else $error("request taken during the re-mask pass");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (.*);

@@ test/bitmap_set_engine_test.sv @@
// Self-checking testbench for bitmap_set_engine: directed and random requests against a shadow set.
`timescale 1ns / 1ps

module bitmap_set_engine_test;
    import bse_pkg::*;

    // Opcodes the block does not define; they only report status
    localparam logic [OP_W-1:0]   SPARE_OP_FIRST  = 4'd10;
    localparam logic [OP_W-1:0]   SPARE_OP_LAST   = 4'd15;
    localparam logic [SIZE_W-1:0] SIZE_FIELD_MAX  = '1;
    localparam int                HOLD_OFF_CYCLES = 300;
    localparam int                QUIET_LIMIT     = 4000;
    localparam int                SETTLE_CYCLES   = 2 * WORD_COUNT + 8;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_word;
        logic [BIDX_W-1:0]    bit_index;
        logic                 found;
        logic                 is_empty;
        logic                 equal_acc;
        logic                 disjoint_acc;
        logic                 subset_acc;
        logic                 bad_index;
    } t_set_result;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata  = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;

    bitmap_set_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Shadow copy of the set, iterator and compare accumulator
    logic [WORD_BITS-1:0]  shadow_words [WORD_COUNT];
    logic [WORD_COUNT-1:0] shadow_nonzero;
    int unsigned           shadow_cursor;
    logic [2:0]            shadow_flags;
    int unsigned           shadow_size;

    t_set_result awaited_results[$];
    t_set_result last_prediction;
    int          send_idle_pct   = 0;
    int          stall_pct       = 0;
    int          hold_off_asked  = 0;
    int          hold_off_given  = 0;
    int          hold_off_left   = 0;
    int          quiet_cycles    = 0;
    int          mismatches      = 0;
    int          results_checked = 0;
    int          requests_sent   = 0;
    int          sizes_written   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned live_words();
        return (shadow_size - 1) / WORD_BITS + 1;
    endfunction

    // Bits of one word that lie below the set size
    function automatic logic [WORD_BITS-1:0] live_mask(input int unsigned idx);
        int unsigned n;
        n = live_words();
        if (idx >= n) return '0;
        if (idx + 1 < n || shadow_size % WORD_BITS == 0) return '1;
        return (32'd1 << (shadow_size % WORD_BITS)) - 32'd1;
    endfunction

    function automatic void store_masked(input int unsigned idx, input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] m;
        m = v & live_mask(idx);
        shadow_words[idx]   = m;
        shadow_nonzero[idx] = (m != '0);
    endfunction

    // Clamp the new size and trim every stored word to it
    function automatic void apply_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            shadow_size = 1;
        end else if (int'(v) > CAP_BITS) begin
            shadow_size = CAP_BITS;
        end else begin
            shadow_size = 32'(v);
        end
        for (int i = 0; i < WORD_COUNT; i++) store_masked(i, shadow_words[i]);
    endfunction

    // Advance the shadow set by one request and return the result it yields
    function automatic t_set_result run_request(input logic [OP_W-1:0] op,
                                                input logic [WI_W-1:0] wi,
                                                input logic [WORD_BITS-1:0] wv);
        t_set_result          r;
        logic [WORD_BITS-1:0] w;
        int unsigned          pos;
        int unsigned          k;
        logic                 hit;
        logic                 is_indexed;
        r          = '0;
        hit        = 1'b0;
        is_indexed = (op >= OP_WRITE) && (op <= OP_COMPARE);
        if (is_indexed && wi >= live_words()) begin
            r.bad_index = 1'b1;
        end else begin
            if (is_indexed) wv &= live_mask(32'(wi));
            case (op)
                OP_CLEAR: begin
                    for (int i = 0; i < WORD_COUNT; i++) store_masked(i, '0);
                end
                OP_SETALL: begin
                    for (int i = 0; i < WORD_COUNT; i++) store_masked(i, '1);
                end
                OP_WRITE: begin
                    r.read_word = shadow_words[wi];
                    store_masked(32'(wi), wv);
                end
                OP_READ: begin
                    r.read_word = shadow_words[wi];
                end
                OP_UNION: begin
                    store_masked(32'(wi), shadow_words[wi] | wv);
                    r.read_word = shadow_words[wi];
                end
                OP_INTERSECT: begin
                    store_masked(32'(wi), shadow_words[wi] & wv);
                    r.read_word = shadow_words[wi];
                end
                OP_SUBTRACT: begin
                    store_masked(32'(wi), shadow_words[wi] & ~wv);
                    r.read_word = shadow_words[wi];
                end
                OP_COMPARE: begin
                    w = shadow_words[wi];
                    // restart the accumulator at word zero
                    if (wi == '0) shadow_flags = '1;
                    if (w != wv) shadow_flags[F_EQUAL] = 1'b0;
                    if ((w & wv) != '0) shadow_flags[F_DISJOINT] = 1'b0;
                    if ((w & ~wv) != '0) shadow_flags[F_SUBSET] = 1'b0;
                    r.read_word = w;
                end
                OP_ITERSTART: begin
                    shadow_cursor = 0;
                end
                OP_ITERNEXT: begin
                    pos = shadow_cursor;
                    while (pos < shadow_size && !hit) begin
                        k = pos / WORD_BITS;
                        w = shadow_nonzero[k] ? (shadow_words[k] >> (pos % WORD_BITS)) : '0;
                        if (w == '0) begin
                            pos = (k + 1) * WORD_BITS;
                        end else begin
                            while (!w[0]) begin
                                w = w >> 1;
                                pos++;
                            end
                            hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        r.found       = 1'b1;
                        r.bit_index   = BIDX_W'(pos);
                        shadow_cursor = pos + 1;
                    end else begin
                        shadow_cursor = shadow_size;
                    end
                end
                default: begin
                end
            endcase
        end
        r.is_empty     = (shadow_nonzero == '0);
        r.equal_acc    = shadow_flags[F_EQUAL];
        r.disjoint_acc = shadow_flags[F_DISJOINT];
        r.subset_acc   = shadow_flags[F_SUBSET];
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [WORD_BITS-1:0] want,
                                      input logic [WORD_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_set_result want;
        t_set_result got;
        int          bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                mismatches++;
            end else begin
                want             = awaited_results.pop_front();
                got.read_word    = o_m_tdata[WORD_BITS-1:0];
                got.bit_index    = o_m_tdata[O_BIDX_LSB +: BIDX_W];
                got.found        = o_m_tdata[O_FOUND];
                got.is_empty     = o_m_tdata[O_EMPTY];
                got.equal_acc    = o_m_tdata[O_EQUAL];
                got.disjoint_acc = o_m_tdata[O_DISJOINT];
                got.subset_acc   = o_m_tdata[O_SUBSET];
                got.bad_index    = o_m_tdata[O_BAD];
                bad = field_diff("read_word", want.read_word, got.read_word)
                    + field_diff("bit_index", WORD_BITS'(want.bit_index),
                                 WORD_BITS'(got.bit_index))
                    + field_diff("found", WORD_BITS'(want.found), WORD_BITS'(got.found))
                    + field_diff("is_empty", WORD_BITS'(want.is_empty),
                                 WORD_BITS'(got.is_empty))
                    + field_diff("equal_so_far", WORD_BITS'(want.equal_acc),
                                 WORD_BITS'(got.equal_acc))
                    + field_diff("disjoint_so_far", WORD_BITS'(want.disjoint_acc),
                                 WORD_BITS'(got.disjoint_acc))
                    + field_diff("subset_so_far", WORD_BITS'(want.subset_acc),
                                 WORD_BITS'(got.subset_acc))
                    + field_diff("bad_index", WORD_BITS'(want.bad_index),
                                 WORD_BITS'(got.bad_index));
                if (bad != 0) mismatches++;
                results_checked++;
            end
        end
    end

    // Drive result ready: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_off_asked != hold_off_given) begin
            i_m_tready     <= 1'b0;
            hold_off_given <= hold_off_asked;
            hold_off_left  <= HOLD_OFF_CYCLES - 1;
        end else if (hold_off_left > 0) begin
            i_m_tready    <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stop the run when no handshake happens for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, awaited_results.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, hold until taken, then maybe idle
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WI_W-1:0] wi,
                                input logic [WORD_BITS-1:0] wv);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({wv, wi, op});
        do @(posedge i_clk); while (!o_s_tready);
        last_prediction = run_request(op, wi, wv);
        awaited_results.push_back(last_prediction);
        if (op <= OP_ITERNEXT) requests_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_size(v);
        sizes_written++;
    endtask

    function automatic logic [WORD_BITS-1:0] pattern_word();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            3: return $urandom;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Mostly live words, sometimes anywhere
    function automatic logic [WI_W-1:0] pick_index();
        if ($urandom_range(9) == 0) return WI_W'($urandom_range(WORD_COUNT - 1));
        return WI_W'($urandom_range(live_words() - 1));
    endfunction

    task automatic test_reset_state();
        send_request(OP_READ, '0, '0);
        send_request(OP_ITERNEXT, '0, '0);
        send_request(OP_COMPARE, 6'd5, '1);
    endtask

    task automatic test_word_ops();
        send_request(OP_SETALL, '0, '0);
        send_request(OP_READ, WI_W'(WORD_COUNT - 1), '0);
        send_request(OP_WRITE, '0, 32'h0000_0100);
        send_request(OP_WRITE, WI_W'(WORD_COUNT - 1), '0);
        send_request(OP_UNION, WI_W'(WORD_COUNT - 1), 32'h8000_0001);
        send_request(OP_INTERSECT, WI_W'(WORD_COUNT - 1), 32'h8000_0000);
        send_request(OP_SUBTRACT, 6'd1, 32'h7FFF_FFFF);
        // compare stream restarting at word zero
        send_request(OP_COMPARE, '0, 32'h0000_0100);
        send_request(OP_COMPARE, 6'd1, '1);
        send_request(OP_ITERSTART, '0, '0);
        send_request(OP_ITERNEXT, '0, '0);
        send_request(OP_ITERNEXT, '0, '0);
        send_request(SPARE_OP_FIRST, '0, '0);
        send_request(SPARE_OP_LAST, '1, '1);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_ITERNEXT, '0, '0);
    endtask

    task automatic test_size_limits();
        // partial last word and indexes past the live words
        drain();
        write_size(12'd33);
        send_request(OP_WRITE, 6'd1, '1);
        send_request(OP_READ, 6'd2, '0);
        send_request(OP_ITERSTART, '0, '0);
        send_request(OP_ITERNEXT, '0, '0);
        // zero acts as one bit, an oversize value as the capacity
        drain();
        write_size('0);
        send_request(OP_UNION, '0, '1);
        send_request(OP_WRITE, 6'd1, '1);
        drain();
        write_size(SIZE_FIELD_MAX);
    endtask

    task automatic run_random(input int count);
        int                   stop_at;
        int                   kind;
        int                   len;
        int unsigned          idx;
        logic [WORD_BITS-1:0] v;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_request(OP_W'($urandom_range(int'(OP_SUBTRACT), int'(OP_WRITE))),
                             pick_index(), pattern_word());
            end else if (kind < 48) begin
                // compare stream, usually from word zero over the live words
                idx = ($urandom_range(9) == 0) ? pick_index() : 0;
                len = $urandom_range(1, live_words());
                for (int i = 0; i < len && idx + i < WORD_COUNT; i++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: v = shadow_words[idx + i];
                        5, 6:          v = shadow_words[idx + i] | $urandom;
                        7:             v = ~shadow_words[idx + i];
                        default:       v = $urandom;
                    endcase
                    send_request(OP_COMPARE, WI_W'(idx + i), v);
                end
            end else if (kind < 68) begin
                // iterator walk until exhausted or cut short
                send_request(OP_ITERSTART, '0, '0);
                len = $urandom_range(2, 16);
                for (int i = 0; i < len; i++) begin
                    send_request(OP_ITERNEXT, '0, '0);
                    if (!last_prediction.found) break;
                end
            end else if (kind < 72) begin
                send_request(($urandom_range(3) == 0) ? OP_SETALL : OP_CLEAR, '0, '0);
            end else if (kind < 78) begin
                // noise: any opcode, any index
                send_request(OP_W'($urandom_range(int'(SPARE_OP_LAST))),
                             WI_W'($urandom_range(WORD_COUNT - 1)), $urandom);
            end else if (kind < 90) begin
                send_request(OP_ITERNEXT, '0, '0);
            end else begin
                // sprinkle sparse words for the iterator to find
                repeat (3) send_request(OP_WRITE, pick_index(), 32'd1 << $urandom_range(31));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [SIZE_W-1:0] size,
                             input int count);
        drain();
        write_size(size);
        send_idle_pct = idle;
        stall_pct     = stall;
        run_random(count);
    endtask

    // Hold results off long enough that the block stops taking requests
    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_asked <= hold_off_asked + 1;
        repeat (24) begin
            send_request(OP_W'($urandom_range(int'(OP_READ), int'(OP_WRITE))),
                         pick_index(), pattern_word());
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < WORD_COUNT; i++) shadow_words[i] = '0;
        shadow_nonzero = '0;
        shadow_cursor  = 0;
        shadow_flags   = '1;
        shadow_size    = 32'(RESET_SIZE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_word_ops();
        test_size_limits();

        run_phase(0, 0, 12'd2048, 130);
        run_phase(87, 0, SIZE_W'($urandom_range(1, 2048)), 130);
        run_phase(8, 8, 12'd1, 50);
        run_phase(0, 87, SIZE_W'($urandom_range(0, 4095)), 130);
        test_backpressure();
        run_phase(8, 8, SIZE_W'($urandom_range(33, 320)), 130);
        run_phase(0, 0, SIZE_FIELD_MAX, 50);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d size settings; %0d results checked, %0d bad.",
                 requests_sent, sizes_written, results_checked, mismatches);
        $display("Exercised word ops, merges, compare streams, iterator walks and stalls.");
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
